@@ sv/ese_pkg.sv @@
// Shared constants, types and helpers of the ellipsoid surface evaluator.
package ese_pkg;

  // Fixed field widths.
  localparam int AXIS_W     = 24;
  localparam int DIR_W      = 16;
  localparam int DIR_FRAC   = 14;
  localparam int ORG_W      = 20;
  localparam int VEC_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int FRAME_W    = 3 * DIR_W;
  localparam int ORIGIN_W   = 3 * ORG_W;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_A  = 3'd0,
    CFG_AXIS_B  = 3'd1,
    CFG_AXIS_C  = 3'd2,
    CFG_ORIGIN  = 3'd3,
    CFG_FRAME_X = 3'd4,
    CFG_FRAME_Y = 3'd5,
    CFG_FRAME_Z = 3'd6
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [AXIS_W-1:0]  AXIS_RST    = 24'd4096;
  localparam logic [FRAME_W-1:0] FRAME_X_RST = 48'h0000_0000_4000;
  localparam logic [FRAME_W-1:0] FRAME_Y_RST = 48'h0000_4000_0000;
  localparam logic [FRAME_W-1:0] FRAME_Z_RST = 48'h4000_0000_0000;

  // Odd-power sine series in Q30, quarter turn mapped to one.
  localparam logic [30:0] SIN_S9 = 31'd172272;
  localparam logic [30:0] SIN_C [4] = '{31'd5026995, 31'd85569306, 31'd693598668,
                                        31'd1686629713};
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Shift right with rounding half away from zero.
  function automatic logic signed [63:0] round_half_away(input logic signed [63:0] v,
                                                         input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

@@ sv/ellipsoid_surface_eval.sv @@
// Pipelined evaluator of ellipsoid surface points and partial derivatives.
//
//  channel  | direction | handshake                | payload
//  s_axis   | in        | tvalid / tready          | tdata: angle_u, angle_v, order_u, order_v
//  m_axis   | out       | tvalid / tready          | tdata: vec_x, vec_y, vec_z; tuser: saturated
//  cfg      | in        | cfg_we_i, no wait        | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle while the output is not stalled, through the 15 register stages of
// the sine series, the length products and the frame products.
// Reset clears every stage valid bit and loads the default configuration.
// A full stage holds its beat while the stage after it is full and stalled; empty
// stages take new beats, so input is accepted while a result waits downstream.
module ellipsoid_surface_eval #(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // angle_u[15:0], angle_v[31:16], order_u[35:32], order_v[39:36]
  input  logic [39:0]                   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // vec_x[31:0], vec_y[63:32], vec_z[95:64]
  output logic [95:0]                   m_axis_tdata_o,
  // saturated[0]
  output logic                          m_axis_tuser_o,
  input  logic                          cfg_we_i,
  input  logic [ese_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ese_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ese_pkg::*;

  localparam int AB    = ANGLE_BITS;
  localparam int TB    = TRIG_BITS;
  localparam int F     = TB - 1;
  localparam int NST   = 15;
  localparam int LANES = 4;
  localparam int P1W   = AXIS_W + 1 + TB;
  localparam int R1W   = AXIS_W + 2;
  localparam int P2W   = R1W + TB;
  localparam int P3W   = R1W + DIR_W;
  localparam int SW    = P3W + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
  localparam logic [AB-1:0] QTR = {2'b01, {(AB - 2){1'b0}}};
  localparam logic [31:0] TRIG_MAX = 32'((64'd1 << F) - 1);
  localparam logic [31:0] TRIG_HALF = 32'(64'd1 << (29 - F));

  // Configuration registers.
  logic [AXIS_W-1:0]   axis_q [3];
  logic [ORIGIN_W-1:0] origin_q;
  logic [FRAME_W-1:0]  frame_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q[0] <= AXIS_RST;
      axis_q[1] <= AXIS_RST;
      axis_q[2] <= AXIS_RST;
      origin_q  <= '0;
      frame_q[0] <= FRAME_X_RST;
      frame_q[1] <= FRAME_Y_RST;
      frame_q[2] <= FRAME_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_AXIS_A: if (cfg_wdata_i[AXIS_W-1:0] != '0) axis_q[0] <= cfg_wdata_i[AXIS_W-1:0];
        CFG_AXIS_B: if (cfg_wdata_i[AXIS_W-1:0] != '0) axis_q[1] <= cfg_wdata_i[AXIS_W-1:0];
        CFG_AXIS_C: if (cfg_wdata_i[AXIS_W-1:0] != '0) axis_q[2] <= cfg_wdata_i[AXIS_W-1:0];
        CFG_ORIGIN:  origin_q   <= cfg_wdata_i[ORIGIN_W-1:0];
        CFG_FRAME_X: frame_q[0] <= cfg_wdata_i[FRAME_W-1:0];
        CFG_FRAME_Y: frame_q[1] <= cfg_wdata_i[FRAME_W-1:0];
        CFG_FRAME_Z: frame_q[2] <= cfg_wdata_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage enables; a stage loads when empty or draining.
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || m_axis_tready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // Stage 0: phase angles of the four sine lanes (sin u, cos u, sin v, cos v).
  logic [AB-1:0] ang_u, ang_v;
  logic [AB-1:0] ang [LANES];
  logic [30:0]   x_d [LANES];
  logic          ng_d [LANES];

  always_comb begin
    ang_u  = AB'(s_axis_tdata_i[15:0]) + {s_axis_tdata_i[33:32], {(AB - 2){1'b0}}};
    ang_v  = AB'(s_axis_tdata_i[31:16]) + {s_axis_tdata_i[37:36], {(AB - 2){1'b0}}};
    ang[0] = ang_u;
    ang[1] = ang_u + QTR;
    ang[2] = ang_v;
    ang[3] = ang_v + QTR;
    for (int l = 0; l < LANES; l++) begin
      x_d[l] = 31'({ang[l][AB-3:0], {(32 - AB){1'b0}}});
      if (ang[l][AB-2]) x_d[l] = Q30_ONE - x_d[l];
      ng_d[l] = ang[l][AB-1];
    end
  end

  // Sine series datapath: square, four Horner steps, final product.
  logic [30:0] x_q  [6][LANES];
  logic        ng_q [7][LANES];
  logic [30:0] x2_q [6][LANES];
  logic [30:0] p_q  [6][LANES];
  logic [30:0] pp_q [LANES];
  logic [61:0] sq_prod [LANES];
  logic [61:0] h_prod  [4][LANES];
  logic [30:0] h_prev  [4][LANES];
  logic [61:0] f_prod  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sq_prod[l] = x_q[0][l] * x_q[0][l];
      for (int h = 0; h < 4; h++) begin
        h_prev[h][l] = (h == 0) ? SIN_S9 : p_q[1+h][l];
        h_prod[h][l] = x2_q[1+h][l] * h_prev[h][l];
      end
      f_prod[l] = x_q[5][l] * p_q[5][l];
    end
  end

  // Trig lanes: round to TRIG_BITS, clamp the value of one, apply the sign.
  logic [31:0]          mag_r [LANES];
  logic [31:0]          mag_c [LANES];
  logic signed [TB-1:0] trig_d [LANES];
  logic signed [TB-1:0] trig_q [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag_r[l]  = (32'(pp_q[l]) + TRIG_HALF) >> (30 - F);
      mag_c[l]  = (mag_r[l] > TRIG_MAX) ? TRIG_MAX : mag_r[l];
      trig_d[l] = ng_q[6][l] ? -$signed(TB'(mag_c[l])) : $signed(TB'(mag_c[l]));
    end
  end

  // Length products and their rounding.
  logic signed [P1W-1:0] pa_q, pb_q, pc_q;
  logic signed [TB-1:0]  cu8_q, su8_q, cu9_q, su9_q;
  logic signed [R1W-1:0] ra_q, rb_q, cz9_q, cz10_q, cx_q, cy_q, cz11_q;
  logic signed [P2W-1:0] qa_q, qb_q;
  logic                  nuz_q [9];
  logic                  pt_q  [14];

  // Frame products, sums and output.
  logic signed [P3W-1:0] m_q [3][3];
  logic signed [SW-1:0]  s_q [3];
  logic signed [SW-1:0]  r_d [3];
  logic [VEC_W-1:0]      out_d [3];
  logic [VEC_W-1:0]      out_q [3];
  logic [2:0]            clip;
  logic                  sat_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_d[k] = SW'(round_half_away(64'(s_q[k]), DIR_FRAC));
      if (pt_q[13]) r_d[k] = r_d[k] + SW'($signed(origin_q[ORG_W*k +: ORG_W]));
      clip[k] = 1'b0;
      out_d[k] = VEC_W'(r_d[k]);
      if (r_d[k] > SAT_HI) begin
        out_d[k] = VEC_W'(SAT_HI);
        clip[k]  = 1'b1;
      end
      if (r_d[k] < SAT_LO) begin
        out_d[k] = VEC_W'(SAT_LO);
        clip[k]  = 1'b1;
      end
    end
  end

  // Payload registers; each stage loads on its own enable.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q[0]   <= x_d;
      ng_q[0]  <= ng_d;
      nuz_q[0] <= (s_axis_tdata_i[35:32] == 4'd0);
      pt_q[0]  <= (s_axis_tdata_i[39:32] == 8'd0);
    end
    for (int k = 1; k < 6; k++) begin
      if (en[k]) x_q[k] <= x_q[k-1];
    end
    for (int k = 1; k < 7; k++) begin
      if (en[k]) ng_q[k] <= ng_q[k-1];
    end
    for (int k = 1; k < 9; k++) begin
      if (en[k]) nuz_q[k] <= nuz_q[k-1];
    end
    for (int k = 1; k < 14; k++) begin
      if (en[k]) pt_q[k] <= pt_q[k-1];
    end
    for (int l = 0; l < LANES; l++) begin
      if (en[1]) x2_q[1][l] <= sq_prod[l][60:30];
    end
    for (int k = 2; k < 6; k++) begin
      if (en[k]) begin
        x2_q[k] <= x2_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          p_q[k][l] <= SIN_C[k-2] - h_prod[k-2][l][60:30];
        end
      end
    end
    for (int l = 0; l < LANES; l++) begin
      if (en[6]) pp_q[l] <= f_prod[l][60:30];
    end
    if (en[7]) trig_q <= trig_d;
    if (en[8]) begin
      pa_q  <= $signed({1'b0, axis_q[0]}) * trig_q[3];
      pb_q  <= $signed({1'b0, axis_q[1]}) * trig_q[3];
      pc_q  <= $signed({1'b0, axis_q[2]}) * trig_q[2];
      cu8_q <= trig_q[1];
      su8_q <= trig_q[0];
    end
    if (en[9]) begin
      ra_q  <= R1W'(round_half_away(64'(pa_q), F));
      rb_q  <= R1W'(round_half_away(64'(pb_q), F));
      cz9_q <= nuz_q[8] ? R1W'(round_half_away(64'(pc_q), F)) : '0;
      cu9_q <= cu8_q;
      su9_q <= su8_q;
    end
    if (en[10]) begin
      qa_q   <= ra_q * cu9_q;
      qb_q   <= rb_q * su9_q;
      cz10_q <= cz9_q;
    end
    if (en[11]) begin
      cx_q   <= R1W'(round_half_away(64'(qa_q), F));
      cy_q   <= R1W'(round_half_away(64'(qb_q), F));
      cz11_q <= cz10_q;
    end
    if (en[12]) begin
      for (int k = 0; k < 3; k++) begin
        m_q[k][0] <= cx_q * $signed(frame_q[0][DIR_W*k +: DIR_W]);
        m_q[k][1] <= cy_q * $signed(frame_q[1][DIR_W*k +: DIR_W]);
        m_q[k][2] <= cz11_q * $signed(frame_q[2][DIR_W*k +: DIR_W]);
      end
    end
    if (en[13]) begin
      for (int k = 0; k < 3; k++) begin
        s_q[k] <= SW'(m_q[k][0]) + SW'(m_q[k][1]) + SW'(m_q[k][2]);
      end
    end
    if (en[14]) begin
      out_q <= out_d;
      sat_q <= |clip;
    end
  end

  assign m_axis_tvalid_o = v_q[NST-1];
  assign m_axis_tdata_o  = {out_q[2], out_q[1], out_q[0]};
  assign m_axis_tuser_o  = sat_q;

`ifndef NO_ASSERTIONS
  // An empty output stage opens the whole pipeline.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready although output stage is empty");

  // A saturated beat carries a clipped component.
  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (out_q[0] == VEC_W'(SAT_HI) || out_q[0] == VEC_W'(SAT_LO) ||
       out_q[1] == VEC_W'(SAT_HI) || out_q[1] == VEC_W'(SAT_LO) ||
       out_q[2] == VEC_W'(SAT_HI) || out_q[2] == VEC_W'(SAT_LO)))
    else $error("saturation flag without a clipped component");

  // A held stage keeps its beat.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-2] && !en[NST-2]) |=> v_q[NST-2])
    else $error("stalled beat dropped inside the pipeline");
`endif

endmodule

@@ sim/tb.sv @@
// Testbench for the ellipsoid surface evaluator: predicts each vector and checks it.
`timescale 1ns / 100ps

module tb;
  import ese_pkg::*;

  localparam int QTURN      = 1 << 14;
  localparam int TRIG_F     = 15;
  localparam int PIPE_LAT   = 15;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  order_v;
    logic [3:0]  order_u;
    logic [15:0] angle_v;
    logic [15:0] angle_u;
  } angles_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] vz;
    logic [31:0] vy;
    logic [31:0] vx;
  } surf_vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Shadow copy of the configuration registers.
  logic [23:0] axis_a, axis_b, axis_c;
  logic [59:0] origin;
  logic [47:0] dir_x, dir_y, dir_z;

  surf_vec_t expected_vecs[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  stall_heavy = 1'b0;

  ellipsoid_surface_eval dut (.*);

  always #4 clk_i = ~clk_i;

  // Quarter-wave polynomial sine in Q30, then rounded to Q1.15.
  function automatic longint bin_sine(input logic [15:0] ang);
    logic [1:0] quad;
    longint unsigned x, x2, p, mag;
    quad = ang[15:14];
    x = longint'(ang[13:0]) << 16;
    if (quad[0]) x = (64'd1 << 30) - x;
    x2 = (x * x) >> 30;
    p = 172272;
    p = 5026995 - ((x2 * p) >> 30);
    p = 85569306 - ((x2 * p) >> 30);
    p = 693598668 - ((x2 * p) >> 30);
    p = 1686629713 - ((x2 * p) >> 30);
    mag = (((x * p) >> 30) + (64'd1 << 14)) >> 15;
    if (mag > 32767) mag = 32767;
    return quad[1] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint rnd_shift(input longint v, input int sh);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic surf_vec_t surface_vector(input angles_t in);
    logic [15:0] au, av;
    longint su, cu, sv, cv, cx, cy, cz, dx, dy, dz, r;
    surf_vec_t res;
    au = in.angle_u + 16'(in.order_u[1:0] * QTURN);
    av = in.angle_v + 16'(in.order_v[1:0] * QTURN);
    su = bin_sine(au);
    cu = bin_sine(au + 16'(QTURN));
    sv = bin_sine(av);
    cv = bin_sine(av + 16'(QTURN));
    cx = rnd_shift(rnd_shift(longint'(axis_a) * cv, TRIG_F) * cu, TRIG_F);
    cy = rnd_shift(rnd_shift(longint'(axis_b) * cv, TRIG_F) * su, TRIG_F);
    cz = (in.order_u == 0) ? rnd_shift(longint'(axis_c) * sv, TRIG_F) : 0;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      dx = longint'($signed(dir_x[16*k +: 16]));
      dy = longint'($signed(dir_y[16*k +: 16]));
      dz = longint'($signed(dir_z[16*k +: 16]));
      r = rnd_shift(cx * dx + cy * dy + cz * dz, DIR_FRAC);
      if (in.order_u == 0 && in.order_v == 0) r += longint'($signed(origin[20*k +: 20]));
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        res.sat = 1'b1;
      end
      if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        res.sat = 1'b1;
      end
      case (k)
        0: res.vx = r[31:0];
        1: res.vy = r[31:0];
        default: res.vz = r[31:0];
      endcase
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    mismatches++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    surf_vec_t got, exp;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tuser_o, m_axis_tdata_o};
        if (expected_vecs.size() == 0) begin
          report("unexpected beat", got.vx, 0);
        end else begin
          exp = expected_vecs.pop_front();
          if (got.vx !== exp.vx) report("vec_x", got.vx, exp.vx);
          if (got.vy !== exp.vy) report("vec_y", got.vy, exp.vy);
          if (got.vz !== exp.vz) report("vec_z", got.vz, exp.vz);
          if (got.sat !== exp.sat) report("saturated", 32'(got.sat), 32'(exp.sat));
        end
      end
      m_axis_tready_i <= stall_heavy ? ($urandom_range(0, 3) == 0)
                                     : ($urandom_range(0, 7) != 0);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_angles(input angles_t in);
    s_axis_tdata_i  <= in;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_vecs.push_back(surface_vector(in));
  endtask

  task automatic drop_valid();
    s_axis_tvalid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_vecs.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [59:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_AXIS_A:  if (val[23:0] != 0) axis_a = val[23:0];
      CFG_AXIS_B:  if (val[23:0] != 0) axis_b = val[23:0];
      CFG_AXIS_C:  if (val[23:0] != 0) axis_c = val[23:0];
      CFG_ORIGIN:  origin = val;
      CFG_FRAME_X: dir_x = val[47:0];
      CFG_FRAME_Y: dir_y = val[47:0];
      CFG_FRAME_Z: dir_z = val[47:0];
      default:     ;
    endcase
  endtask

  function automatic angles_t rand_angles();
    angles_t a;
    a = 40'($urandom);
    a.order_u = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    a.order_v = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    return a;
  endfunction

  task automatic random_burst(input int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) == 0) drop_valid();
        burst = $urandom_range(1, 30);
      end
      burst--;
      send_angles(rand_angles());
    end
    drain();
  endtask

  // Angle extremes, quadrant corners and sixteen order pairs at default settings.
  task automatic test_directed();
    angles_t a;
    logic [15:0] corner[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF};
    foreach (corner[i]) begin
      a = '{order_v: 0, order_u: 0, angle_v: corner[5 - i], angle_u: corner[i]};
      send_angles(a);
    end
    for (int nu = 0; nu < 4; nu++)
      for (int nv = 0; nv < 4; nv++) begin
        a = '{order_v: 4'(nv * 5), order_u: 4'(nu * 5), angle_v: 16'h2000, angle_u: 16'h1234};
        send_angles(a);
      end
    a = '{order_v: 4'hF, order_u: 4'hF, angle_v: 16'h5555, angle_u: 16'hAAAA};
    send_angles(a);
    drain();
  endtask

  // Largest axes and origin and full-scale frames drive the outputs toward their largest magnitudes, short of clipping.
  task automatic test_saturation();
    write_reg(CFG_AXIS_A, 60'hFFFFFF);
    write_reg(CFG_AXIS_B, 60'hFFFFFF);
    write_reg(CFG_AXIS_C, 60'hFFFFFF);
    write_reg(CFG_ORIGIN, 60'h7FFFF_80000_7FFFF);
    write_reg(CFG_FRAME_X, 60'h8000_7FFF_8000);
    write_reg(CFG_FRAME_Y, 60'h7FFF_8000_7FFF);
    write_reg(CFG_FRAME_Z, 60'h8000_8000_7FFF);
    random_burst(150);
  endtask

  // Zero axis writes are ignored; smallest axes otherwise.
  task automatic test_zero_axis();
    write_reg(CFG_AXIS_A, 60'h1);
    write_reg(CFG_AXIS_B, 60'hFFF000000);
    write_reg(CFG_AXIS_C, 60'h1);
    write_reg(CFG_ORIGIN, 60'h80000_7FFFF_80000);
    random_burst(100);
  endtask

  // Random configurations, some phases under heavy back-pressure.
  task automatic test_random_configs();
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_AXIS_A, 60'($urandom_range(1, 24'hFFFFFF)));
      write_reg(CFG_AXIS_B, 60'($urandom >> (8 + $urandom_range(0, 20))));
      write_reg(CFG_AXIS_C, 60'($urandom_range(0, 24'hFFFFFF)));
      write_reg(CFG_ORIGIN, 60'({$urandom, $urandom}));
      write_reg(CFG_FRAME_X, 60'({$urandom, $urandom}));
      write_reg(CFG_FRAME_Y, 60'({$urandom, $urandom}));
      write_reg(CFG_FRAME_Z, 60'({$urandom, $urandom}));
      stall_heavy = p[0];
      random_burst(97);
    end
    stall_heavy = 1'b0;
  endtask

  initial begin
    axis_a = AXIS_RST;
    axis_b = AXIS_RST;
    axis_c = AXIS_RST;
    origin = '0;
    dir_x  = FRAME_X_RST;
    dir_y  = FRAME_Y_RST;
    dir_z  = FRAME_Z_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    random_burst(100);
    test_saturation();
    test_zero_axis();
    test_random_configs();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
